[rtl/core/sha1ce_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers of the SHA-1 compression register block.
package sha1ce_pkg;

  localparam int unsigned ROUNDS  = 80;
  localparam int unsigned RND_W   = $clog2(ROUNDS);
  localparam int unsigned NCHAIN  = 5;
  localparam int unsigned NBUF    = 16;
  localparam int unsigned IDX_W   = $clog2(NCHAIN);

  localparam logic [31:0] START_BIT = 32'h0000_0002;

  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hefcd_ab89;
  localparam logic [31:0] IV2 = 32'h98ba_dcfe;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hc3d2_e1f0;

  localparam logic [31:0] K0 = 32'h5a82_7999;
  localparam logic [31:0] K1 = 32'h6ed9_eba1;
  localparam logic [31:0] K2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K3 = 32'hca62_c1d6;

  typedef enum logic [3:0] {
    SEL_CONTROL   = 4'd0,
    SEL_RESET     = 4'd1,
    SEL_INTSTATUS = 4'd2,
    SEL_INTENABLE = 4'd3,
    SEL_MEMSTART  = 4'd4,
    SEL_MEMMODE   = 4'd5,
    SEL_INSIZE    = 4'd6,
    SEL_HASH      = 4'd7,
    SEL_BUFFER    = 4'd8
  } reg_sel_t;

  typedef logic [NCHAIN-1:0][31:0] word5_t;

  typedef struct packed {
    logic load;   // take chaining words, clear round count
    logic run;    // advance one round
  } core_ctl_t;

  typedef struct packed {
    logic last;   // round being run is the final one
  } core_sts_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

[rtl/core/sha1ce_core.sv]
`timescale 1ns / 1ps
// SHA-1 round datapath: five working words, one round per cycle while run is high.
module sha1ce_core (
  input  logic                clk,
  input  logic                rst,
  input  sha1ce_pkg::core_ctl_t ctl,
  input  sha1ce_pkg::word5_t  chain,
  input  logic [31:0]         w,
  output sha1ce_pkg::word5_t  vars,
  output sha1ce_pkg::core_sts_t sts
);

  logic [sha1ce_pkg::RND_W-1:0] t;
  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, nx;

  always_comb begin
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1ce_pkg::K0;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1ce_pkg::K1;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1ce_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1ce_pkg::K3;
    end
    nx = {a[26:0], a[31:27]} + f + e + k + w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t <= '0;
    end else if (ctl.load) begin
      t <= '0;
    end else if (ctl.run) begin
      t <= t + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctl.run) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= nx;
    end
  end

  assign vars     = {e, d, c, b, a};
  assign sts.last = ctl.run && (t == 7'(sha1ce_pkg::ROUNDS - 1));

endmodule

[rtl/core/sha1_compression_engine_regs.sv]
`timescale 1ns / 1ps
// Register-mapped SHA-1 compression engine: bus front end, sequencer, buffer.
//
// Usage: each input word is one bus access (req_type, reg_sel, word_index,
// write_data) taken when in_valid is high and in_stall low. Every access
// returns exactly one output word (read_data, irq_line) on out_valid, taken
// when out_stall is low. Writes return read_data of zero; irq_line is the
// interrupt level after the access.
// Plain access: its result is registered and shows in the cycle after acceptance,
// and a new access may be taken every cycle while the output drains.
// A control write with the start bit and a written buffer runs the compression:
// the accepting edge loads the round unit, 80 rounds follow (one per cycle),
// then the final state folds the result into the chaining words and presents
// the result; the next access is taken once the sequencer is back in idle.
// in_stall stays high until the result is out. The message buffer doubles as
// the schedule shift line during the rounds and is zeroed in the final state.
// Stall: while out_stall holds a result, in_stall is high; the pending
// result and its payload stay put.
// Reset (rst, synchronous): register file, chaining words and buffer go to zero,
// irq_pending is low, no result is pending; read_data and irq_line keep value.
module sha1_compression_engine_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [3:0]  reg_sel,
  input  logic [3:0]  word_index,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq_line
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  state_t state;

  sha1ce_pkg::word5_t chain;
  logic [31:0] msg_buffer [sha1ce_pkg::NBUF];
  logic        buffer_written;
  logic [31:0] control_word;
  logic [31:0] irq_enable_word;
  logic        irq_pending;
  logic [31:0] mem_start_word;
  logic [31:0] mem_mode_word;
  logic [31:0] in_size_word;

  logic        accept;
  logic        is_start;
  logic        go_compress;
  logic        irq_next;
  logic [31:0] rd;
  logic [31:0] w_new;

  sha1ce_pkg::core_ctl_t core_ctl;
  sha1ce_pkg::core_sts_t core_sts;
  sha1ce_pkg::word5_t    core_vars;

  // Ready only when idle and the output register is free or draining.
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign is_start    = req_type && (reg_sel == sha1ce_pkg::SEL_CONTROL) &&
                       ((write_data & sha1ce_pkg::START_BIT) != '0);
  assign go_compress = accept && is_start && buffer_written;

  // Schedule: w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t]).
  always_comb begin
    w_new = msg_buffer[13] ^ msg_buffer[8] ^ msg_buffer[2] ^ msg_buffer[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  assign core_ctl.load = go_compress;
  assign core_ctl.run  = (state == ST_ROUND);

  sha1ce_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (core_ctl),
    .chain (chain),
    .w     (msg_buffer[0]),
    .vars  (core_vars),
    .sts   (core_sts)
  );

  // Interrupt level after a plain (non-compressing) access.
  always_comb begin
    irq_next = irq_pending;
    if (req_type) begin
      case (reg_sel)
        sha1ce_pkg::SEL_CONTROL: begin
          if (is_start) irq_next = (irq_enable_word != '0);
        end
        sha1ce_pkg::SEL_RESET,
        sha1ce_pkg::SEL_INTSTATUS: irq_next = 1'b0;
        sha1ce_pkg::SEL_INTENABLE: begin
          if (write_data == '0) irq_next = 1'b0;
        end
        default: irq_next = irq_pending;
      endcase
    end
  end

  // Read mux; writes return zero.
  always_comb begin
    rd = '0;
    if (!req_type) begin
      case (reg_sel)
        sha1ce_pkg::SEL_CONTROL:   rd = control_word;
        sha1ce_pkg::SEL_INTSTATUS: rd = {31'b0, irq_pending};
        sha1ce_pkg::SEL_INTENABLE: rd = irq_enable_word;
        sha1ce_pkg::SEL_MEMSTART:  rd = mem_start_word;
        sha1ce_pkg::SEL_MEMMODE:   rd = mem_mode_word;
        sha1ce_pkg::SEL_INSIZE:    rd = in_size_word;
        sha1ce_pkg::SEL_HASH: begin
          if (word_index < 4'(sha1ce_pkg::NCHAIN))
            rd = sha1ce_pkg::swap32(chain[word_index[sha1ce_pkg::IDX_W-1:0]]);
        end
        default: rd = '0;
      endcase
    end
  end

  // Output register and sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (go_compress) state <= ST_ROUND;
          if (accept && !go_compress) begin
            out_valid <= 1'b1;
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        ST_ROUND: begin
          if (core_sts.last) state <= ST_FINAL;
        end
        ST_FINAL: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINAL) begin
      read_data <= '0;
      irq_line  <= (irq_enable_word != '0);
    end else if (accept && !go_compress) begin
      read_data <= rd;
      irq_line  <= irq_next;
    end
  end

  // Register file, chaining words and message buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain           <= '0;
      buffer_written  <= 1'b0;
      control_word    <= '0;
      irq_enable_word <= '0;
      irq_pending     <= 1'b0;
      mem_start_word  <= '0;
      mem_mode_word   <= '0;
      in_size_word    <= '0;
      for (int i = 0; i < sha1ce_pkg::NBUF; i++) msg_buffer[i] <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (go_compress) begin
            irq_pending <= 1'b0;
            // Host words become big-endian message words in place.
            for (int i = 0; i < sha1ce_pkg::NBUF; i++)
              msg_buffer[i] <= sha1ce_pkg::swap32(msg_buffer[i]);
          end else if (accept) begin
            irq_pending <= irq_next;
            if (req_type) begin
              case (reg_sel)
                sha1ce_pkg::SEL_CONTROL: begin
                  if (!is_start) control_word <= write_data;
                end
                sha1ce_pkg::SEL_RESET: begin
                  control_word   <= '0;
                  mem_start_word <= '0;
                  mem_mode_word  <= '0;
                  in_size_word   <= '0;
                  chain          <= {sha1ce_pkg::IV4, sha1ce_pkg::IV3, sha1ce_pkg::IV2,
                                     sha1ce_pkg::IV1, sha1ce_pkg::IV0};
                  buffer_written <= 1'b0;
                  for (int i = 0; i < sha1ce_pkg::NBUF; i++) msg_buffer[i] <= '0;
                end
                sha1ce_pkg::SEL_INTENABLE: irq_enable_word <= write_data;
                sha1ce_pkg::SEL_MEMSTART:  mem_start_word  <= write_data;
                sha1ce_pkg::SEL_MEMMODE:   mem_mode_word   <= write_data;
                sha1ce_pkg::SEL_INSIZE:    in_size_word    <= write_data;
                sha1ce_pkg::SEL_HASH: begin
                  if (word_index < 4'(sha1ce_pkg::NCHAIN))
                    chain[word_index[sha1ce_pkg::IDX_W-1:0]] <=
                      sha1ce_pkg::swap32(write_data);
                end
                sha1ce_pkg::SEL_BUFFER: begin
                  msg_buffer[word_index] <= write_data;
                  buffer_written         <= 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < sha1ce_pkg::NBUF - 1; i++)
            msg_buffer[i] <= msg_buffer[i+1];
          msg_buffer[sha1ce_pkg::NBUF-1] <= w_new;
        end
        ST_FINAL: begin
          for (int i = 0; i < sha1ce_pkg::NCHAIN; i++)
            chain[i] <= chain[i] + core_vars[i];
          for (int i = 0; i < sha1ce_pkg::NBUF; i++) msg_buffer[i] <= '0;
          buffer_written <= 1'b0;
          irq_pending    <= (irq_enable_word != '0);
        end
        default: ;
      endcase
    end
  end

  // Final fold only follows the round phase.
  a_final_after_round: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) |-> $past(state == ST_ROUND))
    else $error("final cycle not preceded by rounds");

  // A compression always ends with a result and a clean buffer.
  a_final_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) |=> (out_valid && !buffer_written))
    else $error("compression finished without result or buffer clear");

  // Rounds only end from the round phase with the last-round flag.
  a_round_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && !core_sts.last) |=> (state == ST_ROUND))
    else $error("round phase left early");

endmodule
